// File: rtl/bqc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_pkg
// shared types, constants and helpers for the biquad cascade filter
// ----------------------------------------------------------------------------
package bqc_pkg;

	// defaults for the top-level parameters
	localparam int DEF_SECTIONS       = 4;
	localparam int DEF_SAMPLE_BITS    = 24;
	localparam int DEF_COEF_FRAC_BITS = 22;

	// fixed formats
	localparam int STATE_BITS         = 48;
	localparam int WIDE_BITS          = 64;
	localparam int NUM_COEFS          = 5;
	localparam int SECTION_FIELD_BITS = 2;
	localparam int COEF_INDEX_BITS    = 3;

	// command codes of an input word
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef enum logic [COEF_INDEX_BITS-1:0] {
		SLOT_B0,
		SLOT_B1,
		SLOT_B2,
		SLOT_A1,
		SLOT_A2
	} coef_slot_t;

	// per-section sequence, at most one multiply per step
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_B0,
		ST_ROUND,
		ST_S1_SUM,
		ST_S1_SUB,
		ST_S2_LOAD,
		ST_S2_END
	} cell_state_t;

	// handoff from one section to the next
	typedef struct packed {
		logic go;
		logic first;
	} cell_link_t;

	// coefficient write broadcast to every section
	typedef struct packed {
		logic                          en;
		logic [SECTION_FIELD_BITS-1:0] section;
		logic [COEF_INDEX_BITS-1:0]    index;
	} coef_wr_t;

	// saturate a wide signed value to the state width
	function automatic logic signed [STATE_BITS-1:0] sat_state(
		input logic signed [WIDE_BITS-1:0] v
	);
		logic [WIDE_BITS-STATE_BITS:0] upper;
		upper = v[WIDE_BITS-1:STATE_BITS-1];
		if ((&upper) || !(|upper)) begin
			return v[STATE_BITS-1:0];
		end else if (v[WIDE_BITS-1]) begin
			return {1'b1, {(STATE_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(STATE_BITS-1){1'b1}}};
		end
	endfunction

endpackage

// File: rtl/bqc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_cell
// one transposed direct form II section with its own coefficients, states and
// a single multiplier stepped through five products
// ----------------------------------------------------------------------------
module bqc_cell
	import bqc_pkg::*;
#(
	parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
	parameter int CELL_ID        = 0,
	localparam int COEF_BITS     = COEF_FRAC_BITS + 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  coef_wr_t                      coef_wr,
	input  logic signed [COEF_BITS-1:0]   coef_value,
	input  cell_link_t                    link_in,
	input  logic signed [SAMPLE_BITS-1:0] x_in,
	output cell_link_t                    link_out,
	output logic signed [SAMPLE_BITS-1:0] y_out
);

	localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
	localparam int RND_BITS  = STATE_BITS + 2;
	localparam int ACC_BITS  = STATE_BITS + 2;
	localparam logic signed [RND_BITS-1:0] RND_HALF =
		RND_BITS'(longint'(1) << (COEF_FRAC_BITS - 1));
	localparam logic SECTION_REACHABLE = (CELL_ID < (1 << SECTION_FIELD_BITS));
	localparam logic [SECTION_FIELD_BITS-1:0] MY_SECTION = SECTION_FIELD_BITS'(CELL_ID);

	cell_state_t state_q, state_d;

	logic signed [COEF_BITS-1:0]   coef_q [NUM_COEFS];
	logic signed [STATE_BITS-1:0]  s1_q, s2_q;
	logic                          first_q;
	logic signed [SAMPLE_BITS-1:0] x_q, y_q;
	logic signed [STATE_BITS-1:0]  prod_q;
	logic signed [ACC_BITS-1:0]    acc_q;

	coef_slot_t                    mul_slot;
	logic                          mul_use_y;
	logic signed [COEF_BITS-1:0]   mul_coef;
	logic signed [SAMPLE_BITS-1:0] mul_data;
	logic signed [PROD_BITS-1:0]   prod;
	logic signed [STATE_BITS-1:0]  prod_sat;

	logic signed [RND_BITS-1:0]    rnd, rsh;
	logic [RND_BITS-SAMPLE_BITS:0] rsh_upper;
	logic signed [SAMPLE_BITS-1:0] y_sat;
	logic                          coef_hit;

	// next state and multiplier operand select
	always_comb begin
		state_d   = state_q;
		mul_slot  = SLOT_B0;
		mul_use_y = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (link_in.go) begin
					state_d = ST_MUL_B0;
				end
			end
			ST_MUL_B0: begin
				mul_slot = SLOT_B0;
				state_d  = ST_ROUND;
			end
			ST_ROUND: begin
				mul_slot = SLOT_B1;
				state_d  = ST_S1_SUM;
			end
			ST_S1_SUM: begin
				mul_slot  = SLOT_A1;
				mul_use_y = 1'b1;
				state_d   = ST_S1_SUB;
			end
			ST_S1_SUB: begin
				mul_slot = SLOT_B2;
				state_d  = ST_S2_LOAD;
			end
			ST_S2_LOAD: begin
				mul_slot  = SLOT_A2;
				mul_use_y = 1'b1;
				state_d   = ST_S2_END;
			end
			ST_S2_END: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign mul_coef = coef_q[mul_slot];
	assign mul_data = mul_use_y ? y_q : x_q;
	assign prod     = PROD_BITS'(mul_coef) * PROD_BITS'(mul_data);
	assign prod_sat = sat_state(WIDE_BITS'(prod));

	// round half up, drop the fraction, saturate to the sample width
	assign rnd       = RND_BITS'(prod_q) + RND_BITS'(s1_q) + RND_HALF;
	assign rsh       = rnd >>> COEF_FRAC_BITS;
	assign rsh_upper = rsh[RND_BITS-1:SAMPLE_BITS-1];
	always_comb begin
		if ((&rsh_upper) || !(|rsh_upper)) begin
			y_sat = rsh[SAMPLE_BITS-1:0];
		end else if (rsh[RND_BITS-1]) begin
			y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	end

	assign coef_hit = coef_wr.en && SECTION_REACHABLE && (coef_wr.section == MY_SECTION)
		&& (coef_wr.index <= SLOT_A2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			first_q <= 1'b0;
			s1_q    <= '0;
			s2_q    <= '0;
			for (int i = 0; i < NUM_COEFS; i++) begin
				coef_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (coef_hit) begin
				coef_q[coef_wr.index] <= coef_value;
			end
			if (state_q == ST_IDLE && link_in.go) begin
				first_q <= link_in.first;
				if (link_in.first) begin
					s1_q <= '0;
					s2_q <= '0;
				end
			end
			if (state_q == ST_S2_LOAD) begin
				s1_q <= sat_state(WIDE_BITS'(acc_q));
			end
			if (state_q == ST_S2_END) begin
				s2_q <= sat_state(WIDE_BITS'(acc_q - ACC_BITS'(prod_q)));
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && link_in.go) begin
			x_q <= x_in;
		end
		prod_q <= prod_sat;
		if (state_q == ST_ROUND) begin
			y_q <= y_sat;
		end
		case (state_q)
			ST_S1_SUM:  acc_q <= ACC_BITS'(prod_q) + ACC_BITS'(s2_q);
			ST_S1_SUB:  acc_q <= acc_q - ACC_BITS'(prod_q);
			ST_S2_LOAD: acc_q <= ACC_BITS'(prod_q);
			default:    acc_q <= acc_q;
		endcase
	end

	assign link_out.go    = (state_q == ST_S2_END);
	assign link_out.first = first_q;
	assign y_out          = y_q;

endmodule

// File: rtl/biquad_cascade_filter.sv
`timescale 1ns / 1ps
// samples go one at a time, a new one only once the last has left the chain and the
//   skid entry is free: each section's single multiplier takes five products and one
//   closing state update in turn
// coefficient loads are accepted while no sample is in flight and the skid is empty
// reset: asynchronous, clears coefficients, section states and all handshake state
// ----------------------------------------------------------------------------
// biquad_cascade_filter
// cascade of second-order sections in transposed direct form II, fixed point,
// built as a chain of section cells that hand each sample down the row
// ----------------------------------------------------------------------------
module biquad_cascade_filter
	import bqc_pkg::*;
#(
	parameter int SECTIONS       = DEF_SECTIONS,
	parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
	localparam int COEF_BITS     = COEF_FRAC_BITS + 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input word
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic                          first,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic [SECTION_FIELD_BITS-1:0] coef_section,
	input  logic [COEF_INDEX_BITS-1:0]    coef_index,
	input  logic signed [COEF_BITS-1:0]   coef_value,
	// output word
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);

	logic     in_fire;
	logic     start;
	logic     done;
	coef_wr_t coef_wr;

	// one link and one sample bus between each pair of neighboring cells
	cell_link_t                    link  [SECTIONS+1];
	logic signed [SAMPLE_BITS-1:0] xs    [SECTIONS+1];

	// a sample is in the chain
	logic                          busy_q;
	// output register plus one skid entry, so the input side keeps moving
	// while a finished word waits downstream
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic                          skid_valid_q;
	logic signed [SAMPLE_BITS-1:0] skid_q;

	// the chain runs one sample at a time; the skid must be free so the
	// result of the next sample always has a place to land
	assign in_ready = !busy_q && !skid_valid_q;
	assign in_fire  = in_valid && in_ready;
	assign start    = in_fire && (command == CMD_SAMPLE);

	// load words broadcast to all cells, each cell picks its own section
	assign coef_wr.en      = in_fire && (command == CMD_LOAD);
	assign coef_wr.section = coef_section;
	assign coef_wr.index   = coef_index;

	// head of the chain: the accepted sample and its first-of-buffer flag
	assign link[0].go    = start;
	assign link[0].first = first;
	assign xs[0]         = sample_in;

	for (genvar i = 0; i < SECTIONS; i++) begin : g_cell
		bqc_cell #(
			.SAMPLE_BITS    (SAMPLE_BITS),
			.COEF_FRAC_BITS (COEF_FRAC_BITS),
			.CELL_ID        (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.coef_wr    (coef_wr),
			.coef_value (coef_value),
			.link_in    (link[i]),
			.x_in       (xs[i]),
			.link_out   (link[i+1]),
			.y_out      (xs[i+1])
		);
	end

	// tail of the chain: last section finished its sample
	assign done = link[SECTIONS].go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				if (!out_valid_q || out_ready) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_valid_q && out_ready) begin
				// refill from the skid or drain
				out_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	// output payload follows the same steering as the valid bits
	always_ff @(posedge clk) begin
		if (done) begin
			if (!out_valid_q || out_ready) begin
				sample_out_q <= xs[SECTIONS];
			end else begin
				skid_q <= xs[SECTIONS];
			end
		end else if (out_valid_q && out_ready && skid_valid_q) begin
			sample_out_q <= skid_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

`ifndef SYNTHESIS
	// the skid only fills behind a held output word
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held without an output word");

	// the chain only finishes a sample it was given
	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy_q)
		else $error("chain finished with no sample in flight");

	// a finished sample never meets a full skid
	a_done_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !skid_valid_q)
		else $error("result word with nowhere to go");

	// a started sample keeps the input closed on the next cycle
	a_start_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !in_ready)
		else $error("input reopened while a sample is in the chain");
`endif

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad cascade filter testbench
// drives coefficient loads and sample words through the valid/ready input,
// runs a fixed-point model of the section chain alongside, and checks every
// filtered sample that leaves the block against it in order
// ----------------------------------------------------------------------------
module testbench;
	import bqc_pkg::*;

	localparam int SECTIONS       = DEF_SECTIONS;
	localparam int SAMPLE_BITS    = DEF_SAMPLE_BITS;
	localparam int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS;
	localparam int COEF_BITS      = COEF_FRAC_BITS + 2;

	// fixed-point landmarks
	localparam int ONE_Q = 1 << COEF_FRAC_BITS;
	localparam logic signed [COEF_BITS-1:0]   COEF_MAX   = {1'b0, {(COEF_BITS-1){1'b1}}};
	localparam logic signed [COEF_BITS-1:0]   COEF_MIN   = {1'b1, {(COEF_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// run length and timing
	localparam int WORD_TARGET    = 1700;
	localparam int LATENCY        = 6 * SECTIONS;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef enum int {
		STALL_NONE,
		STALL_SCATTER,
		STALL_LONG
	} stall_mode_t;

	typedef enum int {
		PROFILE_GENTLE,
		PROFILE_HOT,
		PROFILE_WILD
	} coef_profile_t;

	// ------------------------------------------------------------------------
	// filter model and in-order store of expected output samples
	// ------------------------------------------------------------------------
	class biquad_scoreboard;
		logic signed [COEF_BITS-1:0]   coefs [SECTIONS][NUM_COEFS];
		longint                        s1_model [SECTIONS];
		longint                        s2_model [SECTIONS];
		logic signed [SAMPLE_BITS-1:0] expected_samples [$];
		int                            mismatches;
		int                            samples_taken;
		int                            samples_checked;
		int                            loads_stored;
		int                            loads_dropped;
		int                            buffers_started;

		function new();
			foreach (coefs[s, k]) coefs[s][k] = '0;
			clear_states();
			mismatches      = 0;
			samples_taken   = 0;
			samples_checked = 0;
			loads_stored    = 0;
			loads_dropped   = 0;
			buffers_started = 0;
		endfunction

		function void clear_states();
			foreach (s1_model[s]) begin
				s1_model[s] = 0;
				s2_model[s] = 0;
			end
		endfunction

		static function longint clamp(longint v, int bits);
			longint hi;
			longint lo;
			hi = (longint'(1) <<< (bits - 1)) - 1;
			lo = -hi - 1;
			if (v > hi) return hi;
			if (v < lo) return lo;
			return v;
		endfunction

		// one transposed direct form II section, output rounded half up
		function longint run_section(int s, longint x);
			longint taps [NUM_COEFS];
			longint acc;
			longint y;
			foreach (taps[k]) taps[k] = longint'(coefs[s][k]);
			acc = clamp(taps[SLOT_B0] * x, STATE_BITS) + s1_model[s];
			y = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
			y = clamp(y, SAMPLE_BITS);
			s1_model[s] = clamp(clamp(taps[SLOT_B1] * x, STATE_BITS)
				- clamp(taps[SLOT_A1] * y, STATE_BITS) + s2_model[s], STATE_BITS);
			s2_model[s] = clamp(clamp(taps[SLOT_B2] * x, STATE_BITS)
				- clamp(taps[SLOT_A2] * y, STATE_BITS), STATE_BITS);
			return y;
		endfunction

		function void take_word(bit cmd, bit first_flag, logic signed [SAMPLE_BITS-1:0] x,
			logic [SECTION_FIELD_BITS-1:0] sec, logic [COEF_INDEX_BITS-1:0] idx,
			logic signed [COEF_BITS-1:0] value);
			longint v;
			if (cmd == CMD_LOAD) begin
				// slots past a2 or sections past the chain are dropped
				if (sec < SECTIONS && idx < NUM_COEFS) begin
					coefs[sec][idx] = value;
					loads_stored++;
				end else begin
					loads_dropped++;
				end
				return;
			end
			if (first_flag) begin
				clear_states();
				buffers_started++;
			end
			v = longint'(x);
			for (int s = 0; s < SECTIONS; s++) v = run_section(s, v);
			expected_samples.push_back(v[SAMPLE_BITS-1:0]);
			samples_taken++;
		endfunction

		function void check_sample(logic signed [SAMPLE_BITS-1:0] got);
			logic signed [SAMPLE_BITS-1:0] want;
			if (expected_samples.size() == 0) begin
				$error("sample_out: nothing expected, got %0d", got);
				mismatches++;
				return;
			end
			want = expected_samples.pop_front();
			samples_checked++;
			if (got !== want) begin
				$error("sample_out: expected %0d, got %0d", want, got);
				mismatches++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// clock, reset and block ports
	// ------------------------------------------------------------------------
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                          in_valid     = 1'b0;
	logic                          in_ready;
	logic                          command      = CMD_LOAD;
	logic                          first        = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample_in    = '0;
	logic [SECTION_FIELD_BITS-1:0] coef_section = '0;
	logic [COEF_INDEX_BITS-1:0]    coef_index   = '0;
	logic signed [COEF_BITS-1:0]   coef_value   = '0;
	logic                          out_valid;
	logic                          out_ready    = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	always #5 clk = ~clk;

	biquad_cascade_filter #(
		.SECTIONS       (SECTIONS),
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.first        (first),
		.sample_in    (sample_in),
		.coef_section (coef_section),
		.coef_index   (coef_index),
		.coef_value   (coef_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_out   (sample_out)
	);

	biquad_scoreboard board = new();

	// ------------------------------------------------------------------------
	// monitors: both channels are read right after the edge, so they see the
	// values the block itself sampled
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				board.take_word(command, first, sample_in, coef_section, coef_index,
					coef_value);
			end
			if (out_valid && out_ready) begin
				board.check_sample(sample_out);
			end
		end
	end

	// watchdog: any stretch without a word moved on either side is a hang
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("no word moved for %0d cycles, giving up", idle_cycles);
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// output back-pressure: the stall style switches each time pattern_age wraps, between
	// always ready, scattered random stalls and rare long stalls
	// ------------------------------------------------------------------------
	stall_mode_t stall_mode  = STALL_NONE;
	logic [8:0]  pattern_age = '0;
	int          hold_low    = 0;

	always @(posedge clk) begin
		pattern_age <= pattern_age + 1'b1;
		if (pattern_age == '0) begin
			stall_mode <= stall_mode_t'($urandom_range(STALL_NONE, STALL_LONG));
		end
		if (hold_low != 0) begin
			out_ready <= 1'b0;
			hold_low  <= hold_low - 1;
		end else begin
			case (stall_mode)
				STALL_NONE: begin
					out_ready <= 1'b1;
				end
				STALL_SCATTER: begin
					out_ready <= ($urandom_range(0, 2) != 0);
				end
				default: begin
					if ($urandom_range(0, 19) == 0) begin
						out_ready <= 1'b0;
						hold_low  <= $urandom_range(1, 40);
					end else begin
						out_ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// input side: words go out in bursts with random gaps between them
	// ------------------------------------------------------------------------
	int words_driven = 0;
	int burst_left   = 1;

	// present one word and hold it until the block takes it
	task automatic send_word(input bit cmd, input bit first_flag,
		input logic signed [SAMPLE_BITS-1:0] x, input logic [SECTION_FIELD_BITS-1:0] sec,
		input logic [COEF_INDEX_BITS-1:0] idx, input logic signed [COEF_BITS-1:0] value);
		int gap;
		in_valid     <= 1'b1;
		command      <= cmd;
		first        <= first_flag;
		sample_in    <= x;
		coef_section <= sec;
		coef_index   <= idx;
		coef_value   <= value;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (cmd == CMD_SAMPLE || idx < NUM_COEFS) words_driven++;
		// end of burst: drop valid for a while, or go straight on when the gap is zero
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// the fields a word does not use carry random junk
	task automatic load_coef(input logic [SECTION_FIELD_BITS-1:0] sec,
		input logic [COEF_INDEX_BITS-1:0] idx, input logic signed [COEF_BITS-1:0] value,
		input bit first_flag);
		send_word(CMD_LOAD, first_flag, SAMPLE_BITS'($urandom), sec, idx, value);
	endtask

	task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] x, input bit first_flag);
		send_word(CMD_SAMPLE, first_flag, x, SECTION_FIELD_BITS'($urandom),
			COEF_INDEX_BITS'($urandom), COEF_BITS'($urandom));
	endtask

	function automatic int signed_range(int r);
		return int'($urandom_range(0, 2 * r)) - r;
	endfunction

	// gentle sets stay stable, hot sets ring near the edge, wild sets are any bits
	function automatic logic signed [COEF_BITS-1:0] pick_coef(coef_profile_t profile,
		coef_slot_t slot);
		case (profile)
			PROFILE_GENTLE: begin
				if (slot == SLOT_A2) return COEF_BITS'($urandom_range(0, 3 * ONE_Q / 4));
				if (slot == SLOT_A1) return COEF_BITS'(signed_range(ONE_Q - 1));
				return COEF_BITS'(signed_range(ONE_Q / 2));
			end
			PROFILE_HOT: begin
				if (slot == SLOT_A2) begin
					return COEF_BITS'($urandom_range(7 * ONE_Q / 8, ONE_Q - 1));
				end
				if (slot == SLOT_A1) begin
					return COEF_BITS'(signed_range(ONE_Q + 7 * ONE_Q / 8 - 1));
				end
				return COEF_BITS'(signed_range(int'(COEF_MAX)));
			end
			default: begin
				return COEF_BITS'($urandom);
			end
		endcase
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12) return SAMPLE_BITS'($urandom);
		if (r < 17) return SAMPLE_BITS'(signed_range(4096));
		case ($urandom_range(0, 3))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin
		coef_profile_t profile;
		int            buffer_len;
		int            r;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset every coefficient is zero, so the output is silent
		push_sample(SAMPLE_MAX, 1'b1);

		// unity gain through the chain; a first flag on a load must do nothing
		for (int s = 0; s < SECTIONS; s++) begin
			load_coef(SECTION_FIELD_BITS'(s), SLOT_B0, COEF_BITS'(ONE_Q), s == 0);
		end

		// slots past a2 are dropped
		for (int k = NUM_COEFS; k < 2 ** COEF_INDEX_BITS; k++) begin
			load_coef('0, COEF_INDEX_BITS'(k), '1, 1'b0);
		end

		push_sample(SAMPLE_MAX, 1'b1);
		push_sample(SAMPLE_MIN, 1'b0);
		push_sample('0, 1'b0);
		push_sample('1, 1'b0);
		push_sample(SAMPLE_BITS'(1), 1'b0);

		// extreme gains drive the section outputs into saturation
		load_coef('0, SLOT_B0, COEF_MIN, 1'b0);
		load_coef(SECTION_FIELD_BITS'(SECTIONS - 1), SLOT_B0, COEF_MAX, 1'b0);
		push_sample(SAMPLE_MAX, 1'b0);
		push_sample(SAMPLE_MIN, 1'b0);

		// extreme feedback and feed-forward taps pile up state
		load_coef(SECTION_FIELD_BITS'(1), SLOT_A1, COEF_MIN, 1'b0);
		load_coef(SECTION_FIELD_BITS'(1), SLOT_A2, COEF_MAX, 1'b0);
		load_coef(SECTION_FIELD_BITS'(2), SLOT_B1, COEF_MAX, 1'b0);
		load_coef(SECTION_FIELD_BITS'(2), SLOT_B2, COEF_MIN, 1'b0);
		push_sample(SAMPLE_MAX, 1'b0);
		push_sample(SAMPLE_MIN, 1'b0);
		push_sample(SAMPLE_MAX, 1'b1);

		// random buffers, each after a full or partial coefficient update
		while (words_driven < WORD_TARGET) begin
			r = $urandom_range(0, 9);
			profile = (r < 6) ? PROFILE_GENTLE : (r < 9) ? PROFILE_HOT : PROFILE_WILD;
			if ($urandom_range(0, 4) < 2) begin
				for (int s = 0; s < SECTIONS; s++) begin
					for (int k = 0; k < NUM_COEFS; k++) begin
						load_coef(SECTION_FIELD_BITS'(s), COEF_INDEX_BITS'(k),
							pick_coef(profile, coef_slot_t'(k)), 1'($urandom));
					end
				end
			end else begin
				repeat ($urandom_range(1, 5)) begin
					r = $urandom_range(0, NUM_COEFS - 1);
					load_coef(SECTION_FIELD_BITS'($urandom_range(0, SECTIONS - 1)),
						COEF_INDEX_BITS'(r), pick_coef(profile, coef_slot_t'(r)),
						1'($urandom));
				end
			end

			// noise: any slot code, any value, any flag
			repeat ($urandom_range(0, 3)) begin
				load_coef(SECTION_FIELD_BITS'($urandom), COEF_INDEX_BITS'($urandom),
					COEF_BITS'($urandom), 1'($urandom));
			end

			// most buffers start from rest, a few carry the previous state along
			buffer_len = $urandom_range(8, 60);
			for (int i = 0; i < buffer_len; i++) begin
				push_sample(pick_sample(),
					(i == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 49) == 0));
			end
		end
		in_valid <= 1'b0;

		// drain, then give a stray word time to show up
		while (board.expected_samples.size() != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);

		$display("covered %0d samples in %0d fresh buffers, %0d checked at the output",
			board.samples_taken, board.buffers_started, board.samples_checked);
		$display("coefficient loads: %0d stored, %0d outside the store",
			board.loads_stored, board.loads_dropped);
		if (board.mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
